FILE: rtl/rgbhsv_pkg.sv
// Package with the pixel types, widths and sector codes of the RGB to HSV converter.
package rgbhsv_pkg;

	// Channel and quotient widths.
	localparam int ChanW = 8;
	localparam int QuotW = 8;

	// Hue division: numerator 128*(base*delta - d), divisor 3*delta.
	localparam int HueScaleShift = 7;
	localparam int HueBaseW = 11;
	localparam int HueNumW = HueBaseW + HueScaleShift;
	localparam int HueDivW = 10;

	// Saturation division: numerator delta*255, divisor the largest channel.
	localparam int SatNumW = 16;
	localparam int SatDivW = ChanW;

	// Input item: one RGB pixel.
	typedef struct packed {
		logic [ChanW-1:0] red_in;
		logic [ChanW-1:0] green_in;
		logic [ChanW-1:0] blue_in;
	} rgb_pixel_t;

	// Result item: one HSV pixel.
	typedef struct packed {
		logic [ChanW-1:0] hue;
		logic [ChanW-1:0] saturation;
		logic [ChanW-1:0] brightness;
	} hsv_pixel_t;

	// Hue sector, chosen by the smallest channel.
	typedef enum logic [1:0] {
		SECT_RED_MIN,
		SECT_BLUE_MIN,
		SECT_GREEN_MIN
	} sector_t;

	// Front stage result: gray flag, largest channel, spread, sector and sector offset.
	typedef struct packed {
		logic                    gray;
		logic [ChanW-1:0]        brightness;
		logic [ChanW-1:0]        delta;
		sector_t                 sector;
		logic signed [ChanW:0]   offset;
	} front_t;

	// State of both divisions as it moves down the divider stages.
	typedef struct packed {
		logic                    gray;
		logic [ChanW-1:0]        brightness;
		logic [HueNumW-1:0]      hue_rem;
		logic [HueDivW-1:0]      hue_div;
		logic [QuotW-1:0]        hue_quot;
		logic [SatNumW-1:0]      sat_rem;
		logic [SatDivW-1:0]      sat_div;
		logic [QuotW-1:0]        sat_quot;
	} div_stage_t;

endpackage

FILE: rtl/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter: front stage, numerator stage and two bit-serial pipelined dividers.
// Each item passes the front, numerator, divider and output registers on its way to the result strobe.
// Throughput: one item per cycle; busy is never raised, since every stage advances each cycle.
// The two divisions resolve one quotient bit per stage, which sets the depth of eight stages.
// Reset clears only the valid bits of the stages; items in flight at reset are dropped.
module rgb_to_hsv_converter (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  rgbhsv_pkg::rgb_pixel_t   pixel,
	output logic                     done,
	output rgbhsv_pkg::hsv_pixel_t   hsv
);
	import rgbhsv_pkg::*;

	logic            valid_s1;
	front_t          front_s1;
	front_t          front_d;
	logic [ChanW-1:0] lo;
	logic [ChanW-1:0] hi;

	logic            valid_s [0:QuotW];
	div_stage_t      div_s   [0:QuotW];
	div_stage_t      num_d;
	logic [HueBaseW-1:0]  base_times;
	logic signed [HueBaseW:0] hue_base;

	logic            valid_s11;
	hsv_pixel_t      hsv_s11;

	// The pipeline never stalls, so items are always taken.
	assign busy = 1'b0;

	// Front stage: extremes, spread and sector of the pixel.
	always_comb begin
		lo = pixel.red_in;
		hi = pixel.red_in;
		if (pixel.green_in < lo) lo = pixel.green_in;
		if (pixel.blue_in < lo) lo = pixel.blue_in;
		if (pixel.green_in > hi) hi = pixel.green_in;
		if (pixel.blue_in > hi) hi = pixel.blue_in;
		front_d.brightness = hi;
		front_d.delta = hi - lo;
		front_d.gray = (hi == lo);
		if (pixel.red_in == lo) begin
			front_d.sector = SECT_RED_MIN;
			front_d.offset = $signed({1'b0, pixel.green_in}) - $signed({1'b0, pixel.blue_in});
		end else if (pixel.blue_in == lo) begin
			front_d.sector = SECT_BLUE_MIN;
			front_d.offset = $signed({1'b0, pixel.red_in}) - $signed({1'b0, pixel.green_in});
		end else begin
			front_d.sector = SECT_GREEN_MIN;
			front_d.offset = $signed({1'b0, pixel.blue_in}) - $signed({1'b0, pixel.red_in});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		front_s1 <= front_d;
	end

	// Numerator stage: base times delta by shift and add, less the offset, scaled by 128.
	always_comb begin
		unique case (front_s1.sector)
			SECT_RED_MIN: begin
				base_times = HueBaseW'({front_s1.delta, 1'b0}) + HueBaseW'(front_s1.delta);
			end
			SECT_BLUE_MIN: begin
				base_times = HueBaseW'(front_s1.delta);
			end
			SECT_GREEN_MIN: begin
				base_times = HueBaseW'({front_s1.delta, 2'b00}) + HueBaseW'(front_s1.delta);
			end
			default: begin
				base_times = '0;
			end
		endcase
		// Never negative, since the offset magnitude is at most delta.
		hue_base = $signed({1'b0, base_times}) - (HueBaseW + 1)'($signed(front_s1.offset));
		num_d.gray       = front_s1.gray;
		num_d.brightness = front_s1.brightness;
		num_d.hue_rem    = {hue_base[HueBaseW-1:0], {HueScaleShift{1'b0}}};
		num_d.hue_div    = HueDivW'({front_s1.delta, 1'b0}) + HueDivW'(front_s1.delta);
		num_d.hue_quot   = '0;
		num_d.sat_rem    = {front_s1.delta, {ChanW{1'b0}}} - SatNumW'(front_s1.delta);
		num_d.sat_div    = front_s1.brightness;
		num_d.sat_quot   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		div_s[0] <= num_d;
	end

	// Divider stages: each compares and subtracts the shifted divisors and takes one quotient bit.
	// Both quotients are known to stay below 256, so eight steps cover them.
	for (genvar k = 0; k < QuotW; k++) begin : g_div
		localparam int Sh = QuotW - 1 - k;
		logic [HueNumW-1:0] hue_sh;
		logic [SatNumW-1:0] sat_sh;
		logic               hue_take;
		logic               sat_take;
		div_stage_t         step_d;

		always_comb begin
			hue_sh   = HueNumW'(div_s[k].hue_div) << Sh;
			sat_sh   = SatNumW'(div_s[k].sat_div) << Sh;
			hue_take = (div_s[k].hue_rem >= hue_sh);
			sat_take = (div_s[k].sat_rem >= sat_sh);
			step_d            = div_s[k];
			step_d.hue_rem    = hue_take ? div_s[k].hue_rem - hue_sh : div_s[k].hue_rem;
			step_d.hue_quot   = {div_s[k].hue_quot[QuotW-2:0], hue_take};
			step_d.sat_rem    = sat_take ? div_s[k].sat_rem - sat_sh : div_s[k].sat_rem;
			step_d.sat_quot   = {div_s[k].sat_quot[QuotW-2:0], sat_take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			div_s[k+1] <= step_d;
		end
	end

	// Output register: a zero spread forces hue and saturation to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else begin
			valid_s11 <= valid_s[QuotW];
		end
	end

	always_ff @(posedge clk) begin
		hsv_s11.hue        <= div_s[QuotW].gray ? '0 : div_s[QuotW].hue_quot;
		hsv_s11.saturation <= div_s[QuotW].gray ? '0 : div_s[QuotW].sat_quot;
		hsv_s11.brightness <= div_s[QuotW].brightness;
	end

	assign done = valid_s11;
	assign hsv  = hsv_s11;

endmodule

FILE: sim/rgbhsv_checker.sv
// Checker for the RGB to HSV converter: predicts each pixel's HSV value and compares results.
module rgbhsv_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  rgbhsv_pkg::rgb_pixel_t pixel,
	input  logic                   done,
	input  rgbhsv_pkg::hsv_pixel_t hsv,
	output int                     fail_count,
	output int                     pending
);
	import rgbhsv_pkg::*;

	// Constants of the exact integer hue and saturation formulas.
	localparam int HueHalfScale = 128;
	localparam int SectorDiv    = 3;
	localparam int SatFull      = 255;
	localparam int BaseRedMin   = 3;
	localparam int BaseBlueMin  = 1;
	localparam int BaseGreenMin = 5;

	hsv_pixel_t hsv_expected_q[$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// Exact HSV value of one RGB pixel.
	function automatic hsv_pixel_t hsv_of_pixel(input rgb_pixel_t p);
		int r, g, b, lo, hi, spread, base, d, num;
		sector_t sect;
		hsv_pixel_t h;
		r = int'(p.red_in);
		g = int'(p.green_in);
		b = int'(p.blue_in);
		lo = r;
		hi = r;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		spread = hi - lo;
		h.brightness = 8'(hi);
		if (spread == 0) begin
			// Gray, black or white: no hue and no saturation.
			h.hue        = '0;
			h.saturation = '0;
		end else begin
			// The smallest channel picks the sector; red wins ties, then blue.
			if (r == lo) sect = SECT_RED_MIN;
			else if (b == lo) sect = SECT_BLUE_MIN;
			else sect = SECT_GREEN_MIN;
			case (sect)
				SECT_RED_MIN: begin
					base = BaseRedMin;
					d    = g - b;
				end
				SECT_BLUE_MIN: begin
					base = BaseBlueMin;
					d    = r - g;
				end
				default: begin
					base = BaseGreenMin;
					d    = b - r;
				end
			endcase
			num          = HueHalfScale * (base * spread - d);
			h.hue        = 8'(num / (SectorDiv * spread));
			h.saturation = 8'((spread * SatFull) / hi);
		end
		return h;
	endfunction

	// One line per mismatch, and a count for the verdict.
	task automatic report_mismatch(input string what, input int got, input int want);
		begin
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
			fail_count = fail_count + 1;
		end
	endtask

	// Results are checked before the item of the same edge is queued, since no
	// result can come from the item accepted at that very edge.
	always @(posedge clk) begin
		hsv_pixel_t want;
		if (arst_n) begin
			if (done) begin
				if (hsv_expected_q.size() == 0) begin
					report_mismatch("result with no item outstanding, hue", int'(hsv.hue), -1);
				end else begin
					want = hsv_expected_q.pop_front();
					if (hsv.hue != want.hue)
						report_mismatch("hue", int'(hsv.hue), int'(want.hue));
					if (hsv.saturation != want.saturation)
						report_mismatch("saturation", int'(hsv.saturation),
							int'(want.saturation));
					if (hsv.brightness != want.brightness)
						report_mismatch("brightness", int'(hsv.brightness),
							int'(want.brightness));
				end
			end
			if (start && !busy)
				hsv_expected_q.push_back(hsv_of_pixel(pixel));
			pending <= hsv_expected_q.size();
		end
	end

endmodule

FILE: sim/tb_rgb_to_hsv_converter.sv
// Testbench top for the RGB to HSV converter: clock, reset, pixel stimulus and verdict.
module tb_rgb_to_hsv_converter;
	import rgbhsv_pkg::*;

	localparam int RandomItems = 1000;
	localparam int IdlePercent = 18;
	localparam int StallLimit  = 1000;
	localparam int DrainCycles = 20;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       done;
	rgb_pixel_t pixel;
	hsv_pixel_t hsv;
	int         fail_count;
	int         pending;
	logic       took_item;
	bit         allow_idle;
	int         quiet_cycles;

	rgb_to_hsv_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.hsv    (hsv)
	);

	rgbhsv_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pixel      (pixel),
		.done       (done),
		.hsv        (hsv),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock with a period of four time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Acceptance flag for the driver, and a watchdog on cycles with no traffic.
	always @(posedge clk) begin
		took_item <= arst_n && start && !busy;
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= StallLimit) begin
			$display("FAIL rgb_to_hsv_converter");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one item at a falling edge, with random idle cycles ahead of it,
	// and returns at the falling edge after the item is taken.
	task automatic send_pixel(input rgb_pixel_t p);
		begin
			while (allow_idle && $urandom_range(99) < IdlePercent) begin
				start <= 1'b0;
				pixel <= rgb_pixel_t'($urandom);
				@(posedge clk);
				@(negedge clk);
			end
			start <= 1'b1;
			pixel <= p;
			do begin
				@(posedge clk);
				@(negedge clk);
			end while (!took_item);
		end
	endtask

	task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		rgb_pixel_t p;
		begin
			p.red_in   = r;
			p.green_in = g;
			p.blue_in  = b;
			send_pixel(p);
		end
	endtask

	// Random pixel: mostly uniform, with shares of grays, ties and extreme values.
	function automatic rgb_pixel_t random_pixel();
		rgb_pixel_t p;
		logic [7:0] edges [4];
		int pick;
		edges = '{8'd0, 8'd1, 8'd254, 8'd255};
		p = rgb_pixel_t'($urandom);
		pick = $urandom_range(99);
		if (pick < 10) begin
			p.green_in = p.red_in;
			p.blue_in  = p.red_in;
		end else if (pick < 18) begin
			p.green_in = p.red_in;
		end else if (pick < 26) begin
			p.blue_in = p.red_in;
		end else if (pick < 34) begin
			p.blue_in = p.green_in;
		end else if (pick < 44) begin
			p.red_in   = edges[$urandom_range(3)];
			p.green_in = edges[$urandom_range(3)];
			p.blue_in  = edges[$urandom_range(3)];
		end
		return p;
	endfunction

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		pixel        = '0;
		took_item    = 1'b0;
		quiet_cycles = 0;
		allow_idle   = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items: grays, primaries, each sector, ties and the hue wrap.
		send_rgb(8'd0, 8'd0, 8'd0);
		send_rgb(8'd255, 8'd255, 8'd255);
		send_rgb(8'd128, 8'd128, 8'd128);
		send_rgb(8'd255, 8'd0, 8'd0);
		send_rgb(8'd0, 8'd255, 8'd0);
		send_rgb(8'd0, 8'd0, 8'd255);
		send_rgb(8'd1, 8'd0, 8'd0);
		send_rgb(8'd0, 8'd255, 8'd128);
		send_rgb(8'd200, 8'd100, 8'd10);
		send_rgb(8'd30, 8'd5, 8'd220);
		send_rgb(8'd255, 8'd0, 8'd1);
		send_rgb(8'd255, 8'd254, 8'd255);
		send_rgb(8'd0, 8'd0, 8'd200);
		send_rgb(8'd0, 8'd200, 8'd0);
		send_rgb(8'd200, 8'd0, 8'd0);
		send_rgb(8'd255, 8'd255, 8'd0);
		send_rgb(8'd0, 8'd255, 8'd255);
		send_rgb(8'd255, 8'd0, 8'd255);
		send_rgb(8'd1, 8'd2, 8'd3);
		send_rgb(8'd170, 8'd85, 8'd85);
		send_rgb(8'd254, 8'd255, 8'd254);

		// Random items, with one long stretch offered back to back.
		for (int i = 0; i < RandomItems; i++) begin
			allow_idle = (i < 400) || (i >= 600);
			send_pixel(random_pixel());
		end
		start <= 1'b0;

		// Let every outstanding result arrive, then watch for strays.
		while (pending != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if (fail_count == 0) begin
			$display("PASS rgb_to_hsv_converter");
		end else begin
			$display("FAIL rgb_to_hsv_converter");
		end
		$finish;
	end

endmodule

FILE: rgb_to_hsv_converter.f
rtl/rgbhsv_pkg.sv
rtl/rgb_to_hsv_converter.sv
sim/rgbhsv_checker.sv
sim/tb_rgb_to_hsv_converter.sv
